FILE: design/fsld_pkg.sv
// ----------------------------------------------------------------------------
// fsld_pkg
// shared widths and defaults for the frame scoped loop detector
// ----------------------------------------------------------------------------
package fsld_pkg;
   localparam int unsigned FRAME_DEPTH_DEF = 16;
   localparam int unsigned ENTRIES_PER_FRAME_DEF = 64;
   localparam int unsigned ADDR_W = 64;
   localparam int unsigned BYTES_W = 16;
   localparam int unsigned TAG_W = 20;
endpackage

FILE: design/fsld_ram.sv
// ----------------------------------------------------------------------------
// fsld_ram
// generic single port ram, one write or one registered read per cycle
// ----------------------------------------------------------------------------
module fsld_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

FILE: design/frame_scoped_loop_detector.sv
// ----------------------------------------------------------------------------
// frame_scoped_loop_detector
// per-routine frame stack with loop detection over recorded block pairs
// ----------------------------------------------------------------------------
// sequence: the frame search, then the entry walk (a read then a compare per entry
// through one ram port), the pop and a second search over the frame registers,
// then the start and end entry writes and the response
// throughput: one item at a time, req_stall high from accept until the result is taken
// reset: synchronous, clears frame count, entry counts and the sequencer
module frame_scoped_loop_detector
   import fsld_pkg::*;
#(
   parameter int unsigned FRAME_DEPTH = FRAME_DEPTH_DEF,
   parameter int unsigned ENTRIES_PER_FRAME = ENTRIES_PER_FRAME_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [ADDR_W-1:0]  req_block_start,
   input  logic [BYTES_W-1:0] req_block_bytes,
   input  logic [ADDR_W-1:0]  req_stack_pointer,
   input  logic [TAG_W-1:0]   req_routine_tag,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_loop_found,
   output logic               rsp_frame_overflow,
   output logic               rsp_entry_overflow
);
   localparam int unsigned FW = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
   localparam int unsigned CW = $clog2(FRAME_DEPTH + 1);
   localparam int unsigned EW = (ENTRIES_PER_FRAME > 1) ? $clog2(ENTRIES_PER_FRAME) : 1;
   localparam int unsigned NW = $clog2(ENTRIES_PER_FRAME + 1);
   localparam int unsigned DEPTH = FRAME_DEPTH * ENTRIES_PER_FRAME;
   localparam int unsigned AW = $clog2(DEPTH) > 0 ? $clog2(DEPTH) : 1;

   // one-hot sequencer
   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_FIND   = 9'b000000010,
      S_SCAN   = 9'b000000100,
      S_CMP    = 9'b000001000,
      S_POP    = 9'b000010000,
      S_FIND2  = 9'b000100000,
      S_WRS    = 9'b001000000,
      S_WRE    = 9'b010000000,
      S_RSP    = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // latched item
   logic [ADDR_W-1:0] start_ff, start_in, end_ff, end_in, sp_ff, sp_in;
   logic [TAG_W-1:0]  tag_ff, tag_in;

   // frame register file
   logic [ADDR_W-1:0] fsp_ff [FRAME_DEPTH];
   logic [TAG_W-1:0]  frt_ff [FRAME_DEPTH];
   logic [NW-1:0]     ecnt_ff [FRAME_DEPTH];
   logic [CW-1:0]     fcnt_ff, fcnt_in;

   // walk state
   logic [CW-1:0] idx_ff, idx_in;     // frame walk, counts down
   logic [FW-1:0] slot_ff, slot_in;
   logic          hit_ff, hit_in;     // new frame opened
   logic [NW-1:0] k_ff, k_in;         // entry walk
   logic          loop_ff, loop_in, fovf_ff, fovf_in, eovf_ff, eovf_in;

   // shared ram port
   logic          ram_we, ram_sel_end;
   logic [AW-1:0] ram_addr;
   logic [ADDR_W-1:0] rd_start, rd_end, wr_data;

   logic [FW-1:0] top;
   logic [FW-1:0] walk;
   logic [AW-1:0] base;
   logic [NW-1:0] n_slot;

   assign walk = idx_ff[FW-1:0] - FW'(1);
   assign top = fcnt_ff[FW-1:0] - FW'(1);
   assign n_slot = ecnt_ff[slot_ff];
   assign base = AW'(slot_ff) * AW'(ENTRIES_PER_FRAME);

   fsld_ram #(.WIDTH(ADDR_W), .DEPTH(DEPTH)) u_start_ram (
      .clock(clock), .wr_en(ram_we && !ram_sel_end), .addr(ram_addr),
      .wr_data(wr_data), .rd_data(rd_start)
   );
   fsld_ram #(.WIDTH(ADDR_W), .DEPTH(DEPTH)) u_end_ram (
      .clock(clock), .wr_en(ram_we && ram_sel_end), .addr(ram_addr),
      .wr_data(wr_data), .rd_data(rd_end)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RSP);
   assign rsp_loop_found = loop_ff;
   assign rsp_frame_overflow = fovf_ff;
   assign rsp_entry_overflow = eovf_ff;

   always_comb begin
      state_in = state_ff;
      start_in = start_ff;
      end_in = end_ff;
      sp_in = sp_ff;
      tag_in = tag_ff;
      fcnt_in = fcnt_ff;
      idx_in = idx_ff;
      slot_in = slot_ff;
      hit_in = hit_ff;
      k_in = k_ff;
      loop_in = loop_ff;
      fovf_in = fovf_ff;
      eovf_in = eovf_ff;
      ram_we = 1'b0;
      ram_sel_end = 1'b0;
      ram_addr = base + AW'(k_ff[EW-1:0]);
      wr_data = start_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               start_in = req_block_start;
               end_in = req_block_start + ADDR_W'(req_block_bytes);
               sp_in = req_stack_pointer;
               tag_in = req_routine_tag;
               idx_in = fcnt_ff;
               hit_in = 1'b0;
               loop_in = 1'b0;
               fovf_in = 1'b0;
               eovf_in = 1'b0;
               state_in = S_FIND;
            end
         end
         // search frames top down for the routine
         S_FIND: begin
            if (idx_ff == '0) begin
               state_in = S_POP;
            end else if (frt_ff[walk] == tag_ff) begin
               slot_in = walk;
               k_in = '0;
               state_in = S_SCAN;
            end else begin
               idx_in = idx_ff - CW'(1);
            end
         end
         // issue reads over the frame's entries
         S_SCAN: begin
            if (k_ff >= n_slot || k_ff >= NW'(ENTRIES_PER_FRAME)) begin
               state_in = S_POP;
            end else begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (rd_start == start_ff || rd_end == end_ff) begin
               loop_in = 1'b1;
               state_in = S_POP;
            end else begin
               k_in = k_ff + NW'(1);
               state_in = S_SCAN;
            end
         end
         // pop frames whose sp is below the new one
         S_POP: begin
            if (fcnt_ff != '0 && fsp_ff[top] < sp_ff) begin
               fcnt_in = fcnt_ff - CW'(1);
            end else begin
               idx_in = fcnt_ff;
               state_in = S_FIND2;
            end
         end
         S_FIND2: begin
            if (idx_ff == '0) begin
               if (fcnt_ff >= CW'(FRAME_DEPTH)) begin
                  fovf_in = 1'b1;
                  state_in = S_RSP;
               end else begin
                  slot_in = fcnt_ff[FW-1:0];
                  fcnt_in = fcnt_ff + CW'(1);
                  hit_in = 1'b1;
                  state_in = S_WRS;
               end
            end else if (frt_ff[walk] == tag_ff) begin
               slot_in = walk;
               state_in = S_WRS;
            end else begin
               idx_in = idx_ff - CW'(1);
            end
         end
         S_WRS: begin
            if (n_slot >= NW'(ENTRIES_PER_FRAME)) begin
               eovf_in = 1'b1;
               state_in = S_RSP;
            end else begin
               ram_addr = base + AW'(n_slot[EW-1:0]);
               ram_we = 1'b1;
               state_in = S_WRE;
            end
         end
         S_WRE: begin
            ram_addr = base + AW'(n_slot[EW-1:0]);
            ram_we = 1'b1;
            ram_sel_end = 1'b1;
            wr_data = end_ff;
            state_in = S_RSP;
         end
         S_RSP: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fcnt_ff <= '0;
         for (int i = 0; i < FRAME_DEPTH; i++) begin
            ecnt_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         fcnt_ff <= fcnt_in;
         // popped frame loses its entries
         if (state_ff == S_POP && fcnt_in != fcnt_ff) begin
            ecnt_ff[top] <= '0;
         end
         // new frame opened
         if (state_ff == S_FIND2 && state_in == S_WRS && hit_in && !hit_ff) begin
            fsp_ff[fcnt_ff[FW-1:0]] <= sp_ff;
            frt_ff[fcnt_ff[FW-1:0]] <= tag_ff;
            ecnt_ff[fcnt_ff[FW-1:0]] <= '0;
         end
         if (state_ff == S_WRE) begin
            ecnt_ff[slot_ff] <= n_slot + NW'(1);
         end
      end
      start_ff <= start_in;
      end_ff <= end_in;
      sp_ff <= sp_in;
      tag_ff <= tag_in;
      idx_ff <= idx_in;
      slot_ff <= slot_in;
      hit_ff <= hit_in;
      k_ff <= k_in;
      loop_ff <= loop_in;
      fovf_ff <= fovf_in;
      eovf_ff <= eovf_in;
   end
endmodule
